>>> rtl/dpq_pkg.sv
package dpq_pkg;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_INSERT     = 2'd0,
        CMD_REMOVE_MAX = 2'd1,
        CMD_REMOVE_MIN = 2'd2,
        CMD_NONE       = 2'd3
    } dpq_cmd_t;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Per-cycle action broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_LOAD   = 2'd1,
        CELL_ROTATE = 2'd2,
        CELL_CLOSE  = 2'd3
    } dpq_cell_op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_CLOSE  = 2'd2,
        ST_RESULT = 2'd3
    } dpq_state_t;

endpackage

>>> rtl/dpq_cell.sv
module dpq_cell
    import dpq_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int SLOT     = 0,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
)
(
    input  logic               clk,
    input  dpq_cell_op_t       op,
    input  logic [CNT_W-1:0]   count,
    input  logic [CNT_W-1:0]   mark,
    input  logic [31:0]        load_id,
    input  logic signed [31:0] load_priority,
    input  logic [31:0]        next_id,
    input  logic signed [31:0] next_priority,
    input  logic [31:0]        head_id,
    input  logic signed [31:0] head_priority,
    output logic [31:0]        slot_id,
    output logic signed [31:0] slot_priority
);

    localparam logic [CNT_W-1:0] SLOT_POS = CNT_W'(SLOT);

    logic [31:0]        id_reg;
    logic [31:0]        id_next;
    logic signed [31:0] priority_reg;
    logic signed [31:0] priority_next;
    logic [CNT_W-1:0]   last_pos;

    assign last_pos = count - 1'b1;

    // Pick the word this cell holds next cycle
    always_comb
    begin
        id_next       = id_reg;
        priority_next = priority_reg;
        unique case (op)
            CELL_HOLD:
            begin
                id_next       = id_reg;
                priority_next = priority_reg;
            end
            CELL_LOAD:
            begin
                if (SLOT_POS == count)
                begin
                    id_next       = load_id;
                    priority_next = load_priority;
                end
            end
            CELL_ROTATE:
            begin
                // last occupied cell takes the head word, the rest advance
                if (SLOT_POS == last_pos)
                begin
                    id_next       = head_id;
                    priority_next = head_priority;
                end
                else
                begin
                    id_next       = next_id;
                    priority_next = next_priority;
                end
            end
            CELL_CLOSE:
            begin
                // close the gap at and above the removed slot
                if (SLOT_POS >= mark)
                begin
                    id_next       = next_id;
                    priority_next = next_priority;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        priority_reg <= priority_next;
    end

    assign slot_id       = id_reg;
    assign slot_priority = priority_reg;

endmodule

>>> rtl/double_ended_priority_queue_unit.sv
// Channel  Handshake           Words carried
// -------  ------------------  ---------------------------------------
// in       in_valid/in_stall   cmd, entry_id, entry_priority
// out      out_valid/out_stall removed_id, status
//
// An insert gives no word. An insert into a full table or a removal from an
// empty one gives a status word. Any other removal rotates the cell chain once
// per stored entry past the single comparator at the head, then closes the
// gap, then hands the word to the output register.
// Reset (rst_n low, asynchronous) empties the table and drops any output word.
// in_stall is high while a command is in progress; a waiting output word
// holds the sequencer in its result state until out_stall falls.
module double_ended_priority_queue_unit
    import dpq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [31:0]        entry_id,
    input  logic signed [31:0] entry_priority,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        removed_id,
    output logic [1:0]         status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    dpq_state_t         state_reg;
    dpq_state_t         state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   scan_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [31:0]        best_id_reg;
    logic signed [31:0] best_priority_reg;
    logic               want_max_reg;
    logic [31:0]        res_id_reg;
    logic [1:0]         res_status_reg;
    logic               out_valid_reg;
    logic [31:0]        removed_id_reg;
    logic [1:0]         status_reg;

    dpq_cmd_t           in_cmd;
    dpq_cell_op_t       cell_op;
    logic               accept;
    logic               out_free;
    logic               scan_last;
    logic               head_wins;
    logic [CNT_W-1:0]   mark;

    logic [31:0]        cell_id       [CAPACITY];
    logic signed [31:0] cell_priority [CAPACITY];

    assign in_cmd    = dpq_cmd_t'(cmd);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign scan_last = (scan_reg == count_reg - 1'b1);
    assign mark      = CNT_W'(best_idx_reg);

    // Strict compare keeps the earliest arrival among equal priorities
    assign head_wins = (scan_reg == '0) ||
                       (want_max_reg ? (cell_priority[0] > best_priority_reg)
                                     : (cell_priority[0] < best_priority_reg));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority case (in_cmd)
                        CMD_INSERT:
                        begin
                            if (count_reg == FULL_COUNT)
                                state_next = ST_RESULT;
                        end
                        CMD_REMOVE_MAX, CMD_REMOVE_MIN:
                        begin
                            if (count_reg == '0)
                                state_next = ST_RESULT;
                            else
                                state_next = ST_SCAN;
                        end
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                    state_next = ST_CLOSE;
            end
            ST_CLOSE:
                state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_stall = 1'b1;
        cell_op  = CELL_HOLD;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && in_cmd == CMD_INSERT && count_reg != FULL_COUNT)
                    cell_op = CELL_LOAD;
            end
            ST_SCAN:
                cell_op = CELL_ROTATE;
            ST_CLOSE:
                cell_op = CELL_CLOSE;
            ST_RESULT:
                cell_op = CELL_HOLD;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cell_op == CELL_LOAD)
                count_reg <= count_reg + 1'b1;
            else if (cell_op == CELL_CLOSE)
                count_reg <= count_reg - 1'b1;
            if (state_reg == ST_RESULT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Scan, pending result and output word
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept)
        begin
            scan_reg     <= '0;
            want_max_reg <= (in_cmd == CMD_REMOVE_MAX);
            res_id_reg   <= '0;
            if (in_cmd == CMD_INSERT)
                res_status_reg <= STATUS_FULL;
            else
                res_status_reg <= STATUS_EMPTY;
        end
        if (state_reg == ST_SCAN)
        begin
            scan_reg <= scan_reg + 1'b1;
            if (head_wins)
            begin
                best_idx_reg      <= scan_reg[IDX_W-1:0];
                best_id_reg       <= cell_id[0];
                best_priority_reg <= cell_priority[0];
            end
        end
        if (state_reg == ST_CLOSE)
        begin
            res_id_reg     <= best_id_reg;
            res_status_reg <= STATUS_OK;
        end
        if (state_reg == ST_RESULT && out_free)
        begin
            removed_id_reg <= res_id_reg;
            status_reg     <= res_status_reg;
        end
    end

    // Chain of storage cells, each fed by its upper neighbor, the top one by cell 0
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [31:0]        nxt_id;
        logic signed [31:0] nxt_priority;

        if (i == CAPACITY - 1)
        begin : g_top
            assign nxt_id       = cell_id[0];
            assign nxt_priority = cell_priority[0];
        end
        else
        begin : g_mid
            assign nxt_id       = cell_id[i+1];
            assign nxt_priority = cell_priority[i+1];
        end

        dpq_cell #(
            .CAPACITY (CAPACITY),
            .SLOT     (i)
        ) u_cell (
            .clk           (clk),
            .op            (cell_op),
            .count         (count_reg),
            .mark          (mark),
            .load_id       (entry_id),
            .load_priority (entry_priority),
            .next_id       (nxt_id),
            .next_priority (nxt_priority),
            .head_id       (cell_id[0]),
            .head_priority (cell_priority[0]),
            .slot_id       (cell_id[i]),
            .slot_priority (cell_priority[i])
        );
    end

    assign out_valid  = out_valid_reg;
    assign removed_id = removed_id_reg;
    assign status     = status_reg;

endmodule

>>> verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dpq_pkg::*;

    localparam int TABLE_DEPTH    = 16;
    localparam int RANDOM_ITEMS   = 1080;
    localparam int MAX_WAIT       = 18;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;
    localparam int SCRIPT_ROWS    = 22;

    // Traffic mix of the random part
    localparam int MIX_FILL     = 0;
    localparam int MIX_DRAIN    = 1;
    localparam int MIX_BALANCED = 2;

    typedef struct packed {
        logic [31:0] id;
        logic [1:0]  status;
    } removal_word_t;

    typedef struct packed {
        dpq_cmd_t    op;
        logic [31:0] id;
        logic [31:0] prio;
        bit          fixed;
        logic [31:0] want_id;
        logic [1:0]  want_status;
    } script_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    dpq_cmd_t           cmd;
    logic [31:0]        entry_id;
    logic signed [31:0] entry_priority;
    logic               out_valid;
    logic               out_stall;
    logic [31:0]        removed_id;
    logic [1:0]         status;

    // Typed expectation that rides along with the current input word
    bit                 row_fixed;
    logic [31:0]        row_id;
    logic [1:0]         row_status;

    // Shadow of the table, in arrival order
    logic [31:0]        held_id[$];
    logic signed [31:0] held_prio[$];
    removal_word_t      pending_results[$];

    int unsigned        mismatches = 0;
    int unsigned        idle_cycles = 0;
    bit                 quick = 1'b0;
    bit                 hold_req = 1'b0;

    double_ended_priority_queue_unit #(
        .CAPACITY(TABLE_DEPTH)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .entry_id       (entry_id),
        .entry_priority (entry_priority),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .removed_id     (removed_id),
        .status         (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one command to the shadow table; return 1 when it yields a word
    function automatic bit serve_command(input dpq_cmd_t op, input logic [31:0] id,
                                        input logic signed [31:0] prio,
                                        output removal_word_t word);
        int best;
        word = '0;
        case (op)
            CMD_INSERT:
            begin
                if (held_id.size() >= TABLE_DEPTH)
                begin
                    word.status = STATUS_FULL;
                    return 1'b1;
                end
                held_id.push_back(id);
                held_prio.push_back(prio);
                return 1'b0;
            end
            CMD_REMOVE_MAX, CMD_REMOVE_MIN:
            begin
                if (held_id.size() == 0)
                begin
                    word.status = STATUS_EMPTY;
                    return 1'b1;
                end
                // Strict compare keeps the earliest arrival among equals
                best = 0;
                for (int i = 1; i < held_id.size(); i++)
                begin
                    if (op == CMD_REMOVE_MAX ? held_prio[i] > held_prio[best]
                                             : held_prio[i] < held_prio[best])
                        best = i;
                end
                word.id = held_id[best];
                word.status = STATUS_OK;
                held_id.delete(best);
                held_prio.delete(best);
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t ERROR: %s", $realtime, msg);
    endtask

    // Predict on accepted input words, check accepted output words
    always @(posedge clk)
    begin
        removal_word_t predicted;
        removal_word_t want;
        bit            got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                got = serve_command(cmd, entry_id, entry_priority, predicted);
                if (row_fixed)
                    pending_results.push_back(removal_word_t'{id: row_id,
                                                              status: row_status});
                else if (got)
                    pending_results.push_back(predicted);
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                    note_error($sformatf("unexpected word id=%h status=%0d",
                                         removed_id, status));
                else
                begin
                    want = pending_results.pop_front();
                    if (removed_id !== want.id)
                        note_error($sformatf("removed_id expected %h actual %h",
                                             want.id, removed_id));
                    if (status !== want.status)
                        note_error($sformatf("status expected %0d actual %0d",
                                             want.status, status));
                end
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    // Hold the output side off for a long stretch
    task automatic hold_output();
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
    endtask

    // Output side: wait a random number of cycles before taking each word
    initial
    begin
        int unsigned n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
                hold_output();
            n = quick ? 0 : $urandom_range(0, MAX_WAIT);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
            begin
                @(negedge clk);
                if (hold_req)
                begin
                    hold_output();
                    out_stall <= 1'b0;
                end
                @(posedge clk);
            end
        end
    end

    // Offer one word after a random gap and hold it until accepted
    task automatic send_word(input dpq_cmd_t op, input logic [31:0] id,
                             input logic [31:0] prio, input bit fixed,
                             input logic [31:0] want_id, input logic [1:0] want_status);
        int unsigned gap;
        @(negedge clk);
        gap = quick ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        cmd            <= op;
        entry_id       <= id;
        entry_priority <= prio;
        row_fixed      <= fixed;
        row_id         <= want_id;
        row_status     <= want_status;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
    endtask

    script_row_t script [SCRIPT_ROWS] = '{
        // removals on an empty table after reset
        '{CMD_REMOVE_MAX, 32'h0, 32'h0, 1'b1, 32'h0, STATUS_EMPTY},
        '{CMD_REMOVE_MIN, 32'h0, 32'h0, 1'b1, 32'h0, STATUS_EMPTY},
        '{CMD_NONE, 32'hDEADBEEF, 32'h1, 1'b0, 32'h0, STATUS_OK},
        // extremes of id and priority
        '{CMD_INSERT, 32'hFFFFFFFF, 32'h7FFFFFFF, 1'b0, 32'h0, STATUS_OK},
        '{CMD_INSERT, 32'h00000000, 32'h80000000, 1'b0, 32'h0, STATUS_OK},
        '{CMD_INSERT, 32'h00000001, 32'h00000000, 1'b0, 32'h0, STATUS_OK},
        '{CMD_REMOVE_MAX, 32'h0, 32'h0, 1'b1, 32'hFFFFFFFF, STATUS_OK},
        '{CMD_REMOVE_MIN, 32'h0, 32'h0, 1'b1, 32'h00000000, STATUS_OK},
        // last entry out, then empty again
        '{CMD_REMOVE_MIN, 32'h0, 32'h0, 1'b1, 32'h00000001, STATUS_OK},
        '{CMD_REMOVE_MIN, 32'h0, 32'h0, 1'b1, 32'h0, STATUS_EMPTY},
        // equal priorities: earliest arrival wins
        '{CMD_INSERT, 32'hA5A5A5A5, 32'h5, 1'b0, 32'h0, STATUS_OK},
        '{CMD_INSERT, 32'h5A5A5A5A, 32'h5, 1'b0, 32'h0, STATUS_OK},
        '{CMD_REMOVE_MAX, 32'h0, 32'h0, 1'b0, 32'h0, STATUS_OK},
        '{CMD_INSERT, 32'h12345678, 32'h5, 1'b0, 32'h0, STATUS_OK},
        '{CMD_REMOVE_MIN, 32'h0, 32'h0, 1'b0, 32'h0, STATUS_OK},
        '{CMD_REMOVE_MAX, 32'h0, 32'h0, 1'b0, 32'h0, STATUS_OK},
        // sign of priority decides order
        '{CMD_INSERT, 32'h00000007, 32'hFFFFFFFF, 1'b0, 32'h0, STATUS_OK},
        '{CMD_INSERT, 32'h00000008, 32'h00000001, 1'b0, 32'h0, STATUS_OK},
        '{CMD_REMOVE_MAX, 32'h0, 32'h0, 1'b0, 32'h0, STATUS_OK},
        '{CMD_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0, STATUS_OK},
        '{CMD_REMOVE_MIN, 32'h0, 32'h0, 1'b0, 32'h0, STATUS_OK},
        '{CMD_REMOVE_MAX, 32'h0, 32'h0, 1'b1, 32'h0, STATUS_EMPTY}
    };

    // Stimulus: directed script, back-pressure fill, then random traffic
    initial
    begin
        int          counted;
        int          mix;
        int          ins_pct;
        dpq_cmd_t    op;
        logic [31:0] id;
        logic [31:0] prio;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        cmd            = CMD_NONE;
        entry_id       = '0;
        entry_priority = '0;
        row_fixed      = 1'b0;
        row_id         = '0;
        row_status     = STATUS_OK;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (script[i])
            send_word(script[i].op, script[i].id, script[i].prio, script[i].fixed,
                      script[i].want_id, script[i].want_status);

        // Fill the table while the output side is held off
        hold_req = 1'b1;
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_word(CMD_INSERT, $urandom, $urandom, 1'b0, 32'h0, STATUS_OK);
        send_word(CMD_INSERT, 32'hCAFEF00D, 32'h0, 1'b1, 32'h0, STATUS_FULL);
        for (int i = 0; i < 4; i++)
            send_word(i[0] ? CMD_REMOVE_MIN : CMD_REMOVE_MAX, 32'h0, 32'h0,
                      1'b0, 32'h0, STATUS_OK);

        // Random traffic in fill, drain and balanced stretches
        counted = 0;
        mix = MIX_BALANCED;
        while (counted < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 39) == 0)
                mix = $urandom_range(MIX_FILL, MIX_BALANCED);
            if ($urandom_range(0, 59) == 0)
                quick = !quick;
            ins_pct = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 25 : 50;
            if ($urandom_range(0, 99) < 3)
                op = CMD_NONE;
            else
            begin
                if ($urandom_range(0, 99) < ins_pct)
                    op = CMD_INSERT;
                else
                    op = $urandom_range(0, 1) ? CMD_REMOVE_MAX : CMD_REMOVE_MIN;
                counted++;
            end
            case ($urandom_range(0, 9))
                0:       id = 32'h0;
                1:       id = 32'hFFFFFFFF;
                default: id = $urandom;
            endcase
            // Small values make ties common
            case ($urandom_range(0, 9))
                0:       prio = 32'h7FFFFFFF;
                1:       prio = 32'h80000000;
                2, 3, 4: prio = $urandom_range(0, 6) - 3;
                default: prio = $urandom;
            endcase
            send_word(op, id, prio, 1'b0, 32'h0, STATUS_OK);
        end

        // Drain and let any late word show up
        @(negedge clk);
        in_valid <= 1'b0;
        quick = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
